>>> hdl/lcd4_pkg.sv
// shared types and constants for the 4-bit character lcd bus controller
`default_nettype none
package lcd4_pkg;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] DISP_CTRL_RST = 8'h0C;
    localparam logic [7:0] FUNC_SET_RST  = 8'h28;

    localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

    localparam logic [7:0]  STROBE_RST  = 8'd1;
    localparam logic [15:0] CMD_WAIT_RST  = 16'd40;
    localparam logic [15:0] CHAR_WAIT_RST = 16'd50;
    localparam logic [15:0] LONG_WAIT_RST = 16'd2000;
    localparam logic [15:0] PWR_WAIT_RST  = 16'd40000;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_CMD    = 3'd1,
        REQ_CHAR   = 3'd2,
        REQ_CURSOR = 3'd3,
        REQ_CLEAR  = 3'd4,
        REQ_DISP   = 3'd5,
        REQ_FUNC   = 3'd6,
        REQ_INIT   = 3'd7
    } t_req_type;

    typedef enum logic [2:0] {
        CFG_STROBE    = 3'd0,
        CFG_CMD_WAIT  = 3'd1,
        CFG_CHAR_WAIT = 3'd2,
        CFG_LONG_WAIT = 3'd3,
        CFG_PWR_WAIT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_POWER = 4'd1,
        PH_PH1   = 4'd2,
        PH_PL1   = 4'd3,
        PH_PH2   = 4'd4,
        PH_PL2   = 4'd5,
        PH_WHH   = 4'd6,
        PH_WHL   = 4'd7,
        PH_WLH   = 4'd8,
        PH_WLL   = 4'd9,
        PH_WAIT  = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        WS_NONE = 2'd0,
        WS_CMD  = 2'd1,
        WS_CHAR = 2'd2,
        WS_LONG = 2'd3
    } t_wait_sel;

    localparam logic [2:0] FLAG_BLINK = 3'd0;
    localparam logic [2:0] FLAG_DISP  = 3'd2;
    localparam logic [2:0] FLAG_LINES = 3'd3;
    localparam logic [2:0] FLAG_WIDTH = 3'd4;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic [1:0] row;
        logic [2:0] flag_select;
        logic       flag_value;
        logic       busy_in;
    } t_req;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       data_drive;
        logic       ready_res;
        logic       rejected;
    } t_res;

    typedef struct packed {
        logic [7:0]  strobe_ticks;
        logic [15:0] command_wait_ticks;
        logic [15:0] char_wait_ticks;
        logic [15:0] long_wait_ticks;
        logic [15:0] powerup_wait_ticks;
    } t_cfg;

endpackage
`default_nettype wire

>>> hdl/lcd4_if.sv
// valid/ready channel interfaces for requests and pin-level results
`default_nettype none
interface lcd4_req_if;
    import lcd4_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lcd4_res_if;
    import lcd4_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/lcd4_cfg.sv
// configuration register bank with plain write port
`default_nettype none
module lcd4_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output lcd4_pkg::t_cfg   o_cfg
);
    import lcd4_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STROBE:    n_cfg.strobe_ticks       = i_cfg_data[7:0];
                CFG_CMD_WAIT:  n_cfg.command_wait_ticks = i_cfg_data;
                CFG_CHAR_WAIT: n_cfg.char_wait_ticks    = i_cfg_data;
                CFG_LONG_WAIT: n_cfg.long_wait_ticks    = i_cfg_data;
                CFG_PWR_WAIT:  n_cfg.powerup_wait_ticks = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strobe_ticks       <= STROBE_RST;
            r_cfg.command_wait_ticks <= CMD_WAIT_RST;
            r_cfg.char_wait_ticks    <= CHAR_WAIT_RST;
            r_cfg.long_wait_ticks    <= LONG_WAIT_RST;
            r_cfg.powerup_wait_ticks <= PWR_WAIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

>>> hdl/lcd4_core.sv
// sequencer state and single-pass update for one request or tick
`default_nettype none
module lcd4_core #(
    parameter int NUM_ROWS = 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  lcd4_pkg::t_req i_req,
    input  lcd4_pkg::t_cfg i_cfg,
    output lcd4_pkg::t_res o_res
);
    import lcd4_pkg::*;

    localparam logic [1:0] LastRow = 2'(NUM_ROWS - 1);

    t_phase     r_phase, n_phase;
    logic [2:0] r_sequence_step, n_sequence_step;
    logic [7:0] r_pending_byte, n_pending_byte;
    logic       r_pending_is_data, n_pending_is_data;
    logic [15:0] r_wait_count, n_wait_count;
    logic [7:0] r_strobe_count, n_strobe_count;
    logic       r_busy_seen, n_busy_seen;
    logic [7:0] r_display_control, n_display_control;
    logic [7:0] r_function_set, n_function_set;
    t_wait_sel  r_wait_sel, n_wait_sel;

    logic       v_start;
    logic       v_finish;
    logic [1:0] v_row;
    logic [15:0] v_wait;
    logic [7:0] v_strobe_m1;

    always_comb begin
        n_phase           = r_phase;
        n_sequence_step   = r_sequence_step;
        n_pending_byte    = r_pending_byte;
        n_pending_is_data = r_pending_is_data;
        n_wait_count      = r_wait_count;
        n_strobe_count    = r_strobe_count;
        n_busy_seen       = r_busy_seen;
        n_display_control = r_display_control;
        n_function_set    = r_function_set;
        n_wait_sel        = r_wait_sel;
        v_start  = 1'b0;
        v_finish = 1'b0;
        v_row    = (i_req.row > LastRow) ? LastRow : i_req.row;
        v_wait   = 16'd0;
        v_strobe_m1 = (i_cfg.strobe_ticks == 8'd0) ? 8'd0 : i_cfg.strobe_ticks - 8'd1;
        o_res = '0;
        o_res.data_drive = 1'b1;

        if (r_phase == PH_IDLE) begin
            if (t_req_type'(i_req.req_type) != REQ_TICK) begin
                n_pending_byte    = i_req.byte_value;
                n_pending_is_data = 1'b0;
                n_sequence_step   = 3'd0;
                n_wait_sel        = WS_CMD;
                v_start           = 1'b1;
                unique case (t_req_type'(i_req.req_type))
                    REQ_TICK: v_start = 1'b0;
                    REQ_CMD: n_wait_sel = WS_NONE;
                    REQ_CHAR: begin
                        n_pending_is_data = 1'b1;
                        n_wait_sel        = WS_CHAR;
                    end
                    REQ_CURSOR: n_pending_byte = ROW_BASE[v_row] + {2'b00, i_req.column};
                    REQ_CLEAR: begin
                        n_pending_byte  = CMD_CLEAR;
                        n_wait_sel      = WS_LONG;
                        n_sequence_step = 3'd1;
                    end
                    REQ_DISP: begin
                        if (i_req.flag_select <= FLAG_DISP)
                            n_display_control[i_req.flag_select] = i_req.flag_value;
                        n_pending_byte = n_display_control;
                    end
                    REQ_FUNC: begin
                        if (i_req.flag_select == FLAG_LINES || i_req.flag_select == FLAG_WIDTH)
                            n_function_set[i_req.flag_select] = i_req.flag_value;
                        n_pending_byte = n_function_set;
                    end
                    REQ_INIT: begin
                        n_pending_byte  = CMD_HOME;
                        n_wait_sel      = WS_LONG;
                        n_sequence_step = 3'd4;
                        if (i_cfg.powerup_wait_ticks != 16'd0) begin
                            v_start      = 1'b0;
                            n_phase      = PH_POWER;
                            n_wait_count = i_cfg.powerup_wait_ticks - 16'd1;
                        end
                    end
                endcase
            end
        end else begin
            o_res.rejected = (t_req_type'(i_req.req_type) != REQ_TICK);
            if (r_phase == PH_POWER || r_phase == PH_WAIT) begin
                if (r_wait_count != 16'd0)
                    n_wait_count = r_wait_count - 16'd1;
                else if (r_phase == PH_POWER)
                    v_start = 1'b1;
                else
                    v_finish = 1'b1;
            end else if (r_strobe_count != 8'd0) begin
                n_strobe_count = r_strobe_count - 8'd1;
            end else begin
                n_strobe_count = v_strobe_m1;
                unique case (r_phase)
                    PH_PH1: begin
                        n_busy_seen = i_req.busy_in;
                        n_phase     = PH_PL1;
                    end
                    PH_PL1: n_phase = PH_PH2;
                    PH_PH2: n_phase = PH_PL2;
                    PH_PL2: n_phase = r_busy_seen ? PH_PH1 : PH_WHH;
                    PH_WHH: n_phase = PH_WHL;
                    PH_WHL: n_phase = PH_WLH;
                    PH_WLH: n_phase = PH_WLL;
                    PH_WLL: begin
                        n_strobe_count = r_strobe_count;
                        unique case (r_wait_sel)
                            WS_NONE: v_wait = 16'd0;
                            WS_CMD:  v_wait = i_cfg.command_wait_ticks;
                            WS_CHAR: v_wait = i_cfg.char_wait_ticks;
                            WS_LONG: v_wait = i_cfg.long_wait_ticks;
                        endcase
                        if (v_wait == 16'd0) begin
                            v_finish = 1'b1;
                        end else begin
                            n_phase      = PH_WAIT;
                            n_wait_count = v_wait - 16'd1;
                        end
                    end
                    PH_IDLE, PH_POWER, PH_WAIT: begin
                        n_strobe_count = r_strobe_count;
                        n_phase        = PH_IDLE;
                    end
                endcase
            end
        end

        if (v_finish) begin
            if (r_sequence_step == 3'd0) begin
                n_phase = PH_IDLE;
            end else begin
                priority case (r_sequence_step)
                    3'd4: begin
                        n_pending_byte = r_function_set;
                        n_wait_sel     = WS_CMD;
                    end
                    3'd3: begin
                        n_pending_byte = r_display_control;
                        n_wait_sel     = WS_CMD;
                    end
                    3'd2: begin
                        n_pending_byte = CMD_CLEAR;
                        n_wait_sel     = WS_LONG;
                    end
                    default: begin
                        n_pending_byte = CMD_HOME;
                        n_wait_sel     = WS_LONG;
                    end
                endcase
                n_pending_is_data = 1'b0;
                n_sequence_step   = r_sequence_step - 3'd1;
                v_start           = 1'b1;
            end
        end

        if (v_start) begin
            n_busy_seen    = 1'b1;
            n_phase        = PH_PH1;
            n_strobe_count = v_strobe_m1;
        end

        unique case (n_phase)
            PH_PH1, PH_PL1, PH_PH2, PH_PL2: begin
                o_res.read_write = 1'b1;
                o_res.data_drive = 1'b0;
                o_res.enable_pin = (n_phase == PH_PH1 || n_phase == PH_PH2);
            end
            PH_WHH, PH_WHL, PH_WLH, PH_WLL, PH_WAIT: begin
                o_res.reg_select  = n_pending_is_data;
                o_res.enable_pin  = (n_phase == PH_WHH || n_phase == PH_WLH);
                o_res.data_nibble = (n_phase == PH_WHH || n_phase == PH_WHL) ?
                                    n_pending_byte[7:4] : n_pending_byte[3:0];
            end
            PH_IDLE, PH_POWER: o_res.data_nibble = 4'd0;
        endcase
        o_res.ready_res = (n_phase == PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_sequence_step   <= 3'd0;
            r_pending_byte    <= 8'd0;
            r_pending_is_data <= 1'b0;
            r_wait_count      <= 16'd0;
            r_strobe_count    <= 8'd0;
            r_busy_seen       <= 1'b1;
            r_display_control <= DISP_CTRL_RST;
            r_function_set    <= FUNC_SET_RST;
            r_wait_sel        <= WS_NONE;
        end else if (i_accept) begin
            r_phase           <= n_phase;
            r_sequence_step   <= n_sequence_step;
            r_pending_byte    <= n_pending_byte;
            r_pending_is_data <= n_pending_is_data;
            r_wait_count      <= n_wait_count;
            r_strobe_count    <= n_strobe_count;
            r_busy_seen       <= n_busy_seen;
            r_display_control <= n_display_control;
            r_function_set    <= n_function_set;
            r_wait_sel        <= n_wait_sel;
        end
    end

    a_idle_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_sequence_step == 3'd0)
        else $error("sequence pending while idle");

    a_req_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_phase == PH_IDLE && t_req_type'(i_req.req_type) != REQ_TICK
        |=> r_phase != PH_IDLE)
        else $error("accepted request did not start");

    a_wait_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_phase == PH_WAIT && r_wait_count != 16'd0 |=> r_phase == PH_WAIT)
        else $error("wait ended early");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.rejected |-> r_phase != PH_IDLE)
        else $error("request rejected while idle");
endmodule
`default_nettype wire

>>> hdl/lcd4_skid.sv
// two-entry result buffer, output register plus skid register
`default_nettype none
module lcd4_skid (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  lcd4_pkg::t_res i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output lcd4_pkg::t_res o_data
);
    import lcd4_pkg::*;

    logic r_out_valid, r_skid_valid;
    t_res r_out_data, r_skid_data;
    logic v_push;

    assign o_ready = !r_skid_valid;
    assign v_push  = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (i_ready) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (v_push) begin
                if (!r_out_valid || i_ready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && i_ready)
            r_out_data <= r_skid_data;
        else if (v_push && (!r_out_valid || i_ready))
            r_out_data <= i_data;
        if (v_push && r_out_valid && !i_ready)
            r_skid_data <= i_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_ready |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid entry lost");

    a_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_push && r_out_valid && !i_ready |=> r_skid_valid)
        else $error("transfer dropped on stall");
endmodule
`default_nettype wire

>>> hdl/char_lcd_4bit_bus_controller.sv
// top level of the 4-bit character lcd bus controller
// the pin levels for an item are registered in the result buffer before they reach o_res
// throughput: one request or tick per cycle while i_req is ready (single-pass update)
// a stalled o_res is absorbed by a two-entry result buffer before i_req stalls
// reset (synchronous, active low): sequencer idle, flags 0x0C and 0x28, timing registers
// back to 1, 40, 50, 2000 and 40000 ticks, result buffer empty
`default_nettype none
module char_lcd_4bit_bus_controller #(
    parameter int NUM_ROWS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lcd4_req_if.sink         i_req,
    lcd4_res_if.source       o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import lcd4_pkg::*;

    t_cfg w_cfg;
    t_res w_res;
    logic w_buf_ready;
    logic w_accept;

    assign i_req.ready = w_buf_ready;
    assign w_accept    = i_req.valid && w_buf_ready;

    lcd4_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    lcd4_core #(
        .NUM_ROWS (NUM_ROWS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_req.data),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    lcd4_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (w_buf_ready),
        .i_data  (w_res),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (o_res.data)
    );
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// self-checking bench for the 4-bit lcd bus controller against a pin-level predictor
`timescale 1ns / 100ps
module tb_top;
    import lcd4_pkg::*;

    localparam int NUM_ROWS    = 4;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TICK_BATCH  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 150;

    localparam logic [2:0] CFG_IDX_TOP  = 3'd7;
    localparam logic [2:0] FLAG_CURSOR  = 3'd1;
    localparam logic [2:0] FLAG_SEL_TOP = 3'd7;
    localparam logic [2:0] SEQ_NONE     = 3'd0;
    localparam logic [2:0] SEQ_HOME     = 3'd1;
    localparam logic [2:0] SEQ_CLEAR    = 3'd2;
    localparam logic [2:0] SEQ_DISP     = 3'd3;
    localparam logic [2:0] SEQ_FUNC     = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    lcd4_req_if req_ch();
    lcd4_res_if res_ch();

    char_lcd_4bit_bus_controller #(.NUM_ROWS(NUM_ROWS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    t_cfg      cfg_shadow;
    t_phase    seq_phase;
    logic [2:0] seq_left;
    logic [7:0] out_byte;
    logic       out_is_data;
    logic [15:0] wait_left;
    logic [7:0] strobe_left;
    logic       poll_busy;
    logic [7:0] disp_ctrl;
    logic [7:0] func_set;
    t_wait_sel  wait_kind;

    t_req req_pend_q[$];
    t_res pins_exp_q[$];
    t_res pins_want;

    int   items_pushed = 0;
    int   items_taken = 0;
    int   err_cnt = 0;
    int   cycle_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_arm = 1'b0;
    logic hold_done;
    int   hold_left;

    function automatic void seq_enter_strobe(t_phase p);
        seq_phase = p;
        strobe_left = (cfg_shadow.strobe_ticks == 8'd0) ? 8'd0 : cfg_shadow.strobe_ticks - 8'd1;
    endfunction

    function automatic void seq_start_byte();
        poll_busy = 1'b1;
        seq_enter_strobe(PH_PH1);
    endfunction

    function automatic void seq_next_byte();
        if (seq_left == SEQ_NONE) begin
            seq_phase = PH_IDLE;
        end else begin
            case (seq_left)
                SEQ_FUNC: begin
                    out_byte = func_set;
                    wait_kind = WS_CMD;
                end
                SEQ_DISP: begin
                    out_byte = disp_ctrl;
                    wait_kind = WS_CMD;
                end
                SEQ_CLEAR: begin
                    out_byte = CMD_CLEAR;
                    wait_kind = WS_LONG;
                end
                default: begin
                    out_byte = CMD_HOME;
                    wait_kind = WS_LONG;
                end
            endcase
            out_is_data = 1'b0;
            seq_left = seq_left - 3'd1;
            seq_start_byte();
        end
    endfunction

    function automatic void seq_advance(logic busy);
        logic [15:0] len;
        if (seq_phase == PH_POWER || seq_phase == PH_WAIT) begin
            if (wait_left != 16'd0)
                wait_left = wait_left - 16'd1;
            else if (seq_phase == PH_POWER)
                seq_start_byte();
            else
                seq_next_byte();
        end else if (seq_phase < PH_PH1 || seq_phase > PH_WLL) begin
            seq_phase = PH_IDLE;
        end else if (strobe_left != 8'd0) begin
            strobe_left = strobe_left - 8'd1;
        end else begin
            if (seq_phase == PH_PH1)
                poll_busy = busy;
            if (seq_phase == PH_PL2) begin
                seq_enter_strobe(poll_busy ? PH_PH1 : PH_WHH);
            end else if (seq_phase == PH_WLL) begin
                case (wait_kind)
                    WS_CMD:  len = cfg_shadow.command_wait_ticks;
                    WS_CHAR: len = cfg_shadow.char_wait_ticks;
                    WS_LONG: len = cfg_shadow.long_wait_ticks;
                    default: len = 16'd0;
                endcase
                if (len == 16'd0) begin
                    seq_next_byte();
                end else begin
                    seq_phase = PH_WAIT;
                    wait_left = len - 16'd1;
                end
            end else begin
                seq_enter_strobe(t_phase'(seq_phase + 4'd1));
            end
        end
    endfunction

    function automatic void seq_take_request(t_req r);
        logic [1:0] row;
        row = r.row;
        out_byte = r.byte_value;
        out_is_data = 1'b0;
        seq_left = SEQ_NONE;
        wait_kind = WS_CMD;
        case (r.req_type)
            REQ_CMD: wait_kind = WS_NONE;
            REQ_CHAR: begin
                out_is_data = 1'b1;
                wait_kind = WS_CHAR;
            end
            REQ_CURSOR: begin
                if (row > NUM_ROWS - 1)
                    row = 2'(NUM_ROWS - 1);
                out_byte = ROW_BASE[row] + {2'b00, r.column};
            end
            REQ_CLEAR: begin
                out_byte = CMD_CLEAR;
                wait_kind = WS_LONG;
                seq_left = SEQ_HOME;
            end
            REQ_DISP: begin
                if (r.flag_select <= FLAG_DISP)
                    disp_ctrl[r.flag_select] = r.flag_value;
                out_byte = disp_ctrl;
            end
            REQ_FUNC: begin
                if (r.flag_select == FLAG_LINES || r.flag_select == FLAG_WIDTH)
                    func_set[r.flag_select] = r.flag_value;
                out_byte = func_set;
            end
            default: begin
                out_byte = CMD_HOME;
                wait_kind = WS_LONG;
                seq_left = SEQ_FUNC;
            end
        endcase
        if (r.req_type == REQ_INIT && cfg_shadow.powerup_wait_ticks != 16'd0) begin
            seq_phase = PH_POWER;
            wait_left = cfg_shadow.powerup_wait_ticks - 16'd1;
        end else begin
            seq_start_byte();
        end
    endfunction

    function automatic t_res lcd_pins_after(t_req r);
        t_res p;
        p = '0;
        if (seq_phase == PH_IDLE) begin
            if (r.req_type != REQ_TICK)
                seq_take_request(r);
        end else begin
            p.rejected = (r.req_type != REQ_TICK);
            seq_advance(r.busy_in);
        end
        p.data_drive = 1'b1;
        if (seq_phase >= PH_PH1 && seq_phase <= PH_PL2) begin
            p.read_write = 1'b1;
            p.data_drive = 1'b0;
            p.enable_pin = (seq_phase == PH_PH1 || seq_phase == PH_PH2);
        end else if (seq_phase >= PH_WHH && seq_phase <= PH_WAIT) begin
            p.reg_select = out_is_data;
            p.enable_pin = (seq_phase == PH_WHH || seq_phase == PH_WLH);
            p.data_nibble = (seq_phase <= PH_WHL) ? out_byte[7:4] : out_byte[3:0];
        end
        p.ready_res = (seq_phase == PH_IDLE);
        return p;
    endfunction

    function automatic t_req any_req();
        t_req r;
        r.req_type    = 3'($urandom_range(7));
        r.byte_value  = 8'($urandom);
        r.column      = 6'($urandom);
        r.row         = 2'($urandom);
        r.flag_select = 3'($urandom);
        r.flag_value  = 1'($urandom);
        r.busy_in     = ($urandom_range(3) == 0);
        return r;
    endfunction

    function automatic t_req tick_item(logic busy);
        t_req r;
        r = any_req();
        r.req_type = REQ_TICK;
        r.busy_in = busy;
        return r;
    endfunction

    function automatic void push_item(t_req r);
        req_pend_q.push_back(r);
        items_pushed++;
    endfunction

    // one request, now and then a tick, followed by ticks, with the odd stray request among them
    function automatic int push_burst();
        t_req r;
        int   n_ticks;
        r = any_req();
        r.req_type = ($urandom_range(9) == 0) ? REQ_TICK : 3'($urandom_range(7, 1));
        push_item(r);
        n_ticks = $urandom_range(28);
        for (int i = 0; i < n_ticks; i++) begin
            r = any_req();
            if ($urandom_range(7) != 0)
                r.req_type = REQ_TICK;
            push_item(r);
        end
        return n_ticks + 1;
    endfunction

    task automatic wait_settled();
        while (items_taken != items_pushed || pins_exp_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_to_idle();
        wait_settled();
        while (seq_phase != PH_IDLE) begin
            for (int i = 0; i < TICK_BATCH; i++)
                push_item(tick_item($urandom_range(3) == 0));
            wait_settled();
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_STROBE:    cfg_shadow.strobe_ticks = val[7:0];
            CFG_CMD_WAIT:  cfg_shadow.command_wait_ticks = val;
            CFG_CHAR_WAIT: cfg_shadow.char_wait_ticks = val;
            CFG_LONG_WAIT: cfg_shadow.long_wait_ticks = val;
            CFG_PWR_WAIT:  cfg_shadow.powerup_wait_ticks = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(logic [7:0] strobe, logic [15:0] cmd_wait,
                                logic [15:0] char_wait, logic [15:0] long_wait,
                                logic [15:0] pwr_wait);
        write_reg(CFG_STROBE, {8'($urandom), strobe});
        write_reg(CFG_CMD_WAIT, cmd_wait);
        write_reg(CFG_CHAR_WAIT, char_wait);
        write_reg(CFG_LONG_WAIT, long_wait);
        write_reg(CFG_PWR_WAIT, pwr_wait);
        write_reg(3'($urandom_range(CFG_IDX_TOP, CFG_PWR_WAIT + 1)), 16'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_small_regs();
        program_regs(8'($urandom_range(3, 1)), 16'($urandom_range(12)),
                     16'($urandom_range(12)), 16'($urandom_range(12)),
                     16'($urandom_range(20)));
    endtask

    task automatic directed_req(t_req_type kind, logic [7:0] b, logic [5:0] col,
                                logic [1:0] row, logic [2:0] sel, logic val);
        t_req r;
        r = any_req();
        r.req_type = kind;
        r.byte_value = b;
        r.column = col;
        r.row = row;
        r.flag_select = sel;
        r.flag_value = val;
        r.busy_in = 1'b0;
        push_item(r);
        run_to_idle();
    endtask

    task automatic random_phase(int idle_pct, int stall_pct, logic with_hold);
        int pushed_here;
        logic paused;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        pushed_here = 0;
        paused = 1'b0;
        while (pushed_here < PHASE_ITEMS) begin
            pushed_here += push_burst();
            if (with_hold && pushed_here > 40)
                hold_arm = 1'b1;
            if (!paused && pushed_here >= PHASE_ITEMS / 2) begin
                wait_settled();
                paused = 1'b1;
            end
        end
        run_to_idle();
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                pins_exp_q.push_back(lcd_pins_after(req_ch.data));
                items_taken++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.valid <= 1'b1;
                    req_ch.data <= req_pend_q.pop_front();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pins_exp_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("cycle %0d: result transfer with nothing expected: %p",
                                 cycle_cnt, res_ch.data);
                end else begin
                    pins_want = pins_exp_q.pop_front();
                    if (res_ch.data.reg_select !== pins_want.reg_select
                            || res_ch.data.read_write !== pins_want.read_write
                            || res_ch.data.enable_pin !== pins_want.enable_pin
                            || res_ch.data.data_nibble !== pins_want.data_nibble
                            || res_ch.data.data_drive !== pins_want.data_drive
                            || res_ch.data.ready_res !== pins_want.ready_res
                            || res_ch.data.rejected !== pins_want.rejected) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("cycle %0d: pin mismatch, expected %p, got %p",
                                     cycle_cnt, pins_want, res_ch.data);
                    end
                end
            end
            res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL char_lcd_4bit_bus_controller");
            $finish;
        end
    end

    initial begin
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_STROBE;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;

        cfg_shadow.strobe_ticks = STROBE_RST;
        cfg_shadow.command_wait_ticks = CMD_WAIT_RST;
        cfg_shadow.char_wait_ticks = CHAR_WAIT_RST;
        cfg_shadow.long_wait_ticks = LONG_WAIT_RST;
        cfg_shadow.powerup_wait_ticks = PWR_WAIT_RST;
        seq_phase = PH_IDLE;
        seq_left = SEQ_NONE;
        out_byte = '0;
        out_is_data = 1'b0;
        wait_left = '0;
        strobe_left = '0;
        poll_busy = 1'b1;
        disp_ctrl = DISP_CTRL_RST;
        func_set = FUNC_SET_RST;
        wait_kind = WS_NONE;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        program_regs(8'd1, 16'd3, 16'd2, 16'd5, 16'd7);
        directed_req(REQ_CMD, 8'h00, 6'd0, 2'd0, FLAG_BLINK, 1'b0);
        directed_req(REQ_CMD, 8'hFF, 6'd63, 2'd3, FLAG_SEL_TOP, 1'b1);
        directed_req(REQ_CHAR, 8'h00, 6'd0, 2'd0, FLAG_BLINK, 1'b0);
        directed_req(REQ_CHAR, 8'hFF, 6'd0, 2'd0, FLAG_BLINK, 1'b0);
        directed_req(REQ_CURSOR, 8'h00, 6'd0, 2'd0, FLAG_BLINK, 1'b0);
        directed_req(REQ_CURSOR, 8'h00, 6'd63, 2'd3, FLAG_BLINK, 1'b0);
        directed_req(REQ_CURSOR, 8'h00, 6'd63, 2'd1, FLAG_BLINK, 1'b0);
        directed_req(REQ_CURSOR, 8'h00, 6'd21, 2'd2, FLAG_BLINK, 1'b0);
        directed_req(REQ_CLEAR, 8'h00, 6'd0, 2'd0, FLAG_BLINK, 1'b0);
        directed_req(REQ_DISP, 8'h00, 6'd0, 2'd0, FLAG_BLINK, 1'b1);
        directed_req(REQ_DISP, 8'h00, 6'd0, 2'd0, FLAG_CURSOR, 1'b1);
        directed_req(REQ_DISP, 8'h00, 6'd0, 2'd0, FLAG_DISP, 1'b0);
        directed_req(REQ_DISP, 8'h00, 6'd0, 2'd0, FLAG_WIDTH, 1'b1);
        directed_req(REQ_FUNC, 8'h00, 6'd0, 2'd0, FLAG_LINES, 1'b0);
        directed_req(REQ_FUNC, 8'h00, 6'd0, 2'd0, FLAG_WIDTH, 1'b1);
        directed_req(REQ_FUNC, 8'h00, 6'd0, 2'd0, FLAG_CURSOR, 1'b1);
        directed_req(REQ_FUNC, 8'h00, 6'd0, 2'd0, FLAG_SEL_TOP, 1'b0);
        directed_req(REQ_INIT, 8'h00, 6'd0, 2'd0, FLAG_BLINK, 1'b0);

        // requests arriving while busy get rejected
        push_item(any_req());
        req_pend_q[$].req_type = REQ_CMD;
        push_item(any_req());
        req_pend_q[$].req_type = REQ_CHAR;
        push_item(any_req());
        req_pend_q[$].req_type = REQ_INIT;
        run_to_idle();

        // display stays busy across several polls
        push_item(any_req());
        req_pend_q[$].req_type = REQ_CHAR;
        for (int i = 0; i < 6; i++)
            push_item(tick_item(1'b1));
        run_to_idle();

        // random part
        program_small_regs();
        random_phase(0, 0, 1'b0);
        program_regs(8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_phase(55, 0, 1'b0);
        program_small_regs();
        random_phase(0, 55, 1'b0);
        program_small_regs();
        random_phase(8, 8, 1'b1);

        // longer strobes, unit and zero waits
        send_idle_pct = 0;
        recv_stall_pct = 0;
        program_regs(8'd6, 16'd9, 16'd9, 16'd1, 16'd1);
        directed_req(REQ_CHAR, 8'hA5, 6'd0, 2'd0, FLAG_BLINK, 1'b0);
        directed_req(REQ_CURSOR, 8'h00, 6'd7, 2'd2, FLAG_BLINK, 1'b0);
        program_regs(8'd1, 16'd1, 16'd1, 16'd0, 16'd40);
        directed_req(REQ_INIT, 8'h00, 6'd0, 2'd0, FLAG_BLINK, 1'b0);
        program_regs(8'd2, 16'd5, 16'd5, 16'd30, 16'd0);
        directed_req(REQ_CLEAR, 8'h00, 6'd0, 2'd0, FLAG_BLINK, 1'b0);

        run_to_idle();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && pins_exp_q.size() == 0)
            $display("PASS char_lcd_4bit_bus_controller");
        else
            $display("FAIL char_lcd_4bit_bus_controller");
        $finish;
    end

endmodule

>>> char_lcd_4bit_bus_controller.f
hdl/lcd4_pkg.sv
hdl/lcd4_if.sv
hdl/lcd4_cfg.sv
hdl/lcd4_core.sv
hdl/lcd4_skid.sv
hdl/char_lcd_4bit_bus_controller.sv
tb/tb_top.sv
